// ===== hdl/agp_pkg.sv =====
`default_nettype none

package agp_pkg;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGMA_LEFT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGMA_RIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SURF_BRIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_POINT  = 3'd4;

    localparam logic [31:0] SIGMA_RESET = 32'd65536;

    localparam longint unsigned LN2_Q30 = 64'd744261118;
    localparam logic signed [25:0] MAG_K_Q24 = 26'sd22293082;
    localparam logic [23:0] GAUSS_K_Q24 = 24'd12102203;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic [24:0] rem0;
        logic [6:0]  low;
        logic [31:0] sig;
        logic        bad;
        logic        clamp;
    } t_job;

    function automatic logic [31:0] exp_taylor(input logic [63:0] x);
        logic [63:0] term;
        logic [63:0] sum;
        term = 64'd1 << 30;
        sum  = term;
        term = ((term * x) >> 30) / 64'd1;  sum = sum + term;
        term = ((term * x) >> 30) / 64'd2;  sum = sum + term;
        term = ((term * x) >> 30) / 64'd3;  sum = sum + term;
        term = ((term * x) >> 30) / 64'd4;  sum = sum + term;
        term = ((term * x) >> 30) / 64'd5;  sum = sum + term;
        term = ((term * x) >> 30) / 64'd6;  sum = sum + term;
        term = ((term * x) >> 30) / 64'd7;  sum = sum + term;
        term = ((term * x) >> 30) / 64'd8;  sum = sum + term;
        term = ((term * x) >> 30) / 64'd9;  sum = sum + term;
        term = ((term * x) >> 30) / 64'd10; sum = sum + term;
        term = ((term * x) >> 30) / 64'd11; sum = sum + term;
        term = ((term * x) >> 30) / 64'd12; sum = sum + term;
        term = ((term * x) >> 30) / 64'd13; sum = sum + term;
        term = ((term * x) >> 30) / 64'd14; sum = sum + term;
        term = ((term * x) >> 30) / 64'd15; sum = sum + term;
        term = ((term * x) >> 30) / 64'd16; sum = sum + term;
        return sum[31:0];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/agp_if.sv =====
`default_nettype none

interface agp_pos_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] position;
    modport source(output valid, output position, input ready);
    modport sink(input valid, input position, output ready);
endinterface

interface agp_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] flux;
    logic        saturated;
    logic        bad_width;
    modport source(output valid, output flux, output saturated, output bad_width, input ready);
    modport sink(input valid, input flux, input saturated, input bad_width, output ready);
endinterface

interface agp_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/asymmetric_gaussian_profile_top.sv =====
// Split Gaussian flux evaluator: one position request in, one flux result out.
// Throughput: one request per cycle while o_res.ready holds, set by the fully pipelined restoring divider.
// A request passes the front register, the job queue, one divider stage per quotient bit,
// and then the exp2 stages before the output register.
// Reset is synchronous, active low; config registers return to their defaults, valid bits clear, pipeline empties.
`default_nettype none

module asymmetric_gaussian_profile_top #(
    parameter int FRAC_BITS         = 16,
    parameter int EXP_TABLE_ENTRIES = 256
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    agp_pos_if.sink   i_pos,
    agp_cfg_if.sink   i_cfg,
    agp_res_if.source o_res
);

    agp_pkg::t_job      w_front_job;
    logic               w_front_valid;
    logic               w_fifo_not_full;
    agp_pkg::t_job      w_fifo_job;
    logic               w_fifo_not_empty;
    logic               w_pop;
    logic signed [16:0] w_m;

    agp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pos       (i_pos),
        .i_cfg       (i_cfg),
        .o_job       (w_front_job),
        .o_job_valid (w_front_valid),
        .i_job_ready (w_fifo_not_full),
        .o_m         (w_m)
    );

    agp_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_front_valid),
        .i_data      (w_front_job),
        .o_not_full  (w_fifo_not_full),
        .i_pop       (w_pop),
        .o_data      (w_fifo_job),
        .o_not_empty (w_fifo_not_empty)
    );

    agp_back #(
        .FRAC_BITS         (FRAC_BITS),
        .EXP_TABLE_ENTRIES (EXP_TABLE_ENTRIES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (w_fifo_job),
        .i_job_valid (w_fifo_not_empty),
        .o_pop       (w_pop),
        .i_m         (w_m),
        .o_res       (o_res)
    );

endmodule

`default_nettype wire

// ===== hdl/agp_front.sv =====
`default_nettype none

module agp_front (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    agp_pos_if.sink           i_pos,
    agp_cfg_if.sink           i_cfg,
    output agp_pkg::t_job     o_job,
    output logic              o_job_valid,
    input  wire logic         i_job_ready,
    output logic signed [16:0] o_m
);

    logic signed [31:0] r_center;
    logic [31:0]        r_sigma_left;
    logic [31:0]        r_sigma_right;
    logic signed [15:0] r_surf;
    logic signed [15:0] r_zp;
    logic               r_vld;
    agp_pkg::t_job      r_job;
    agp_pkg::t_job      n_job;
    logic signed [16:0] r_m;

    logic signed [32:0] w_d;
    logic [32:0]        w_dn;
    logic [31:0]        w_ad;
    logic               w_acc;

    assign i_cfg.ready = 1'b1;
    assign i_pos.ready = !r_vld || i_job_ready;
    assign w_acc = i_pos.valid && i_pos.ready;

    always_comb begin
        w_d  = {i_pos.position[31], i_pos.position} - {r_center[31], r_center};
        w_dn = -w_d;
        w_ad = w_d[32] ? w_dn[31:0] : w_d[31:0];
        n_job.sig   = w_d[32] ? r_sigma_left : r_sigma_right;
        n_job.bad   = (n_job.sig == 32'd0);
        n_job.rem0  = w_ad[31:7];
        n_job.low   = w_ad[6:0];
        n_job.clamp = ({7'd0, w_ad[31:7]} >= n_job.sig);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center      <= '0;
            r_sigma_left  <= agp_pkg::SIGMA_RESET;
            r_sigma_right <= agp_pkg::SIGMA_RESET;
            r_surf        <= '0;
            r_zp          <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                agp_pkg::CFG_CENTER:      r_center      <= i_cfg.data;
                agp_pkg::CFG_SIGMA_LEFT:  r_sigma_left  <= i_cfg.data;
                agp_pkg::CFG_SIGMA_RIGHT: r_sigma_right <= i_cfg.data;
                agp_pkg::CFG_SURF_BRIGHT: r_surf        <= i_cfg.data[15:0];
                agp_pkg::CFG_ZERO_POINT:  r_zp          <= i_cfg.data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_acc) begin
            r_vld <= 1'b1;
        end else if (i_job_ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_job <= n_job;
        end
        r_m <= {r_zp[15], r_zp} - {r_surf[15], r_surf};
    end

    assign o_job       = r_job;
    assign o_job_valid = r_vld;
    assign o_m         = r_m;

endmodule

`default_nettype wire

// ===== hdl/agp_fifo.sv =====
`default_nettype none

module agp_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  agp_pkg::t_job       i_data,
    output logic                o_not_full,
    input  wire logic           i_pop,
    output agp_pkg::t_job       o_data,
    output logic                o_not_empty
);

    agp_pkg::t_job                 r_mem [agp_pkg::FIFO_DEPTH];
    logic [agp_pkg::FIFO_PTR_W-1:0] r_wr;
    logic [agp_pkg::FIFO_PTR_W-1:0] r_rd;
    logic [agp_pkg::FIFO_PTR_W:0]   r_cnt;
    logic                           w_push;
    logic                           w_pop;

    assign o_not_full  = (r_cnt != (agp_pkg::FIFO_PTR_W+1)'(agp_pkg::FIFO_DEPTH));
    assign o_not_empty = (r_cnt != '0);
    assign w_push      = i_push && o_not_full;
    assign w_pop       = i_pop && o_not_empty;
    assign o_data      = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (agp_pkg::FIFO_PTR_W+1)'(w_push)
                           - (agp_pkg::FIFO_PTR_W+1)'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/agp_back.sv =====
`default_nettype none

module agp_back #(
    parameter int FRAC_BITS         = 16,
    parameter int EXP_TABLE_ENTRIES = 256
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  agp_pkg::t_job      i_job,
    input  wire logic          i_job_valid,
    output logic               o_pop,
    input  wire logic signed [16:0] i_m,
    agp_res_if.source          o_res
);

    localparam int F    = FRAC_BITS;
    localparam int N    = EXP_TABLE_ENTRIES;
    localparam int Q    = F + 7;
    localparam int R2W  = F + 13;
    localparam int GW   = F + 12;
    localparam int EMW  = F + 10;
    localparam int EW   = F + 14;
    localparam int KW   = $clog2(N);
    localparam int AW   = $clog2(N + 1);
    localparam int NST  = Q + 9;
    localparam int S_R  = Q + 1;
    localparam int S_OUT = Q + 8;
    localparam logic [Q-1:0] RLIM = {1'b1, {(F + 6){1'b0}}};

    logic [31:0]    w_rom [N + 1];

    for (genvar gi = 0; gi <= N; gi++) begin : g_rom
        if (gi == N) begin : g_top
            assign w_rom[gi] = 32'h8000_0000;
        end else begin : g_ent
            localparam longint unsigned X = (64'(gi) * agp_pkg::LN2_Q30) / N;
            assign w_rom[gi] = agp_pkg::exp_taylor(X);
        end
    end

    logic [NST-1:0] r_vld;
    logic [NST-1:0] r_bad;
    logic           w_en;

    logic [31:0]    r_rem   [Q + 1];
    logic [Q-1:0]   r_low   [Q + 1];
    logic [Q-1:0]   r_quo   [Q + 1];
    logic [31:0]    r_sig   [Q + 1];
    logic [Q:0]     r_clamp;

    logic signed [EMW-1:0] r_em;
    logic signed [42:0]    w_mprod;
    logic signed [42:0]    w_em_full;

    logic [Q-1:0]   r_r;
    logic [2*Q-1:0] w_sq;
    logic [R2W-1:0] r_r2;
    logic [R2W+23:0] w_g;
    logic [GW-1:0]  r_g;
    logic signed [EW-1:0] r_e;
    logic [F+KW:0]  w_u;
    logic signed [13:0] r_ip_u;
    logic [KW-1:0]  r_k;
    logic [F-1:0]   r_q_u;
    logic [AW-1:0]  w_ka;
    logic [AW-1:0]  w_kb;
    logic [31:0]    r_t0;
    logic [31:0]    r_t1;
    logic signed [13:0] r_ip_t;
    logic [F-1:0]   r_q_t;
    logic [31:0]    w_diff;
    logic [30+F:0]  w_dq;
    logic [31:0]    r_mant;
    logic signed [13:0] r_ip_m;
    logic signed [14:0] w_s;
    logic [14:0]    w_ns;
    logic [63:0]    w_shl;
    logic [31:0]    n_flux;
    logic           n_sat;
    logic [31:0]    r_flux;
    logic           r_sat;

    assign w_en  = !r_vld[S_OUT] || o_res.ready;
    assign o_pop = w_en && i_job_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NST-2:0], o_pop};
        end
    end

    assign w_mprod   = i_m * agp_pkg::MAG_K_Q24;
    assign w_em_full = w_mprod >>> (32 - F);

    always_ff @(posedge i_clk) begin
        r_em <= w_em_full[EMW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_bad      <= {r_bad[NST-2:0], i_job.bad};
            r_rem[0]   <= {7'd0, i_job.rem0};
            r_low[0]   <= {i_job.low, {F{1'b0}}};
            r_quo[0]   <= '0;
            r_sig[0]   <= i_job.sig;
            r_clamp[0] <= i_job.clamp;
        end
    end

    for (genvar gj = 1; gj <= Q; gj++) begin : g_div
        logic [32:0] w_trial;
        logic        w_ge;
        logic [32:0] w_sub;
        assign w_trial = {r_rem[gj-1], r_low[gj-1][Q-1]};
        assign w_ge    = (w_trial >= {1'b0, r_sig[gj-1]});
        assign w_sub   = w_trial - {1'b0, r_sig[gj-1]};
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_rem[gj]   <= w_ge ? w_sub[31:0] : w_trial[31:0];
                r_low[gj]   <= r_low[gj-1] << 1;
                r_quo[gj]   <= {r_quo[gj-1][Q-2:0], w_ge};
                r_sig[gj]   <= r_sig[gj-1];
                r_clamp[gj] <= r_clamp[gj-1];
            end
        end
    end

    assign w_sq   = (2*Q)'(r_r) * (2*Q)'(r_r);
    assign w_g    = (R2W+24)'(r_r2) * (R2W+24)'(agp_pkg::GAUSS_K_Q24);
    assign w_u    = (F+KW+1)'(r_e[F-1:0]) * (F+KW+1)'(N);
    assign w_ka   = AW'(r_k);
    assign w_kb   = AW'(r_k) + 1'b1;
    assign w_diff = r_t1 - r_t0;
    assign w_dq   = (31+F)'(w_diff[30:0]) * (31+F)'(r_q_t);
    assign w_s    = {r_ip_m[13], r_ip_m} - 15'sd14;
    assign w_ns   = -w_s;
    assign w_shl  = {32'd0, r_mant} << w_s[4:0];

    always_comb begin
        n_flux = '0;
        n_sat  = 1'b0;
        priority if (r_bad[S_OUT-1]) begin
            n_flux = '0;
        end else if (w_s >= 15'sd32) begin
            n_flux = 32'hFFFF_FFFF;
            n_sat  = 1'b1;
        end else if (w_s >= 15'sd0) begin
            if (w_shl[63:32] != 32'd0) begin
                n_flux = 32'hFFFF_FFFF;
                n_sat  = 1'b1;
            end else begin
                n_flux = w_shl[31:0];
            end
        end else if (w_ns >= 15'd32) begin
            n_flux = '0;
        end else begin
            n_flux = r_mant >> w_ns[4:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_r    <= (r_clamp[Q] || (r_quo[Q] > RLIM)) ? RLIM : r_quo[Q];
            r_r2   <= w_sq[2*F+12:F];
            r_g    <= w_g[GW+23:24];
            r_e    <= {{(EW-EMW){r_em[EMW-1]}}, r_em} - {2'b00, r_g};
            r_ip_u <= r_e[EW-1:F];
            r_k    <= w_u[F+KW-1:F];
            r_q_u  <= w_u[F-1:0];
            r_t0   <= w_rom[w_ka];
            r_t1   <= w_rom[w_kb];
            r_ip_t <= r_ip_u;
            r_q_t  <= r_q_u;
            r_mant <= r_t0 + {2'b00, w_dq[F+29:F]};
            r_ip_m <= r_ip_t;
            r_flux <= n_flux;
            r_sat  <= n_sat;
        end
    end

    assign o_res.valid     = r_vld[S_OUT];
    assign o_res.flux      = r_flux;
    assign o_res.saturated = r_sat;
    assign o_res.bad_width = r_bad[S_OUT];

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[S_OUT] && r_bad[S_OUT]) |-> (r_flux == 32'd0 && !r_sat))
        else $error("bad width result carries nonzero flux");

    a_sat_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[S_OUT] && r_sat) |-> (r_flux == 32'hFFFF_FFFF && !r_bad[S_OUT]))
        else $error("saturated result without full-scale flux");

    a_ratio_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[S_R] |-> (r_r <= RLIM))
        else $error("normalized distance exceeds its clamp");

    a_mant_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[S_OUT-1] && !r_bad[S_OUT-1])
            |-> (r_mant >= 32'h4000_0000 && r_mant <= 32'h8000_0000))
        else $error("interpolated mantissa out of range");

endmodule

`default_nettype wire

// ===== tb/asymmetric_gaussian_profile_top_test.sv =====
`timescale 1ns / 1ps

module asymmetric_gaussian_profile_top_test;

    localparam int FB = 16;
    localparam int NT = 256;
    localparam int LATENCY = 40;

    typedef struct packed {
        logic [31:0] flux;
        logic        saturated;
        logic        bad_width;
    } flux_res_t;

    typedef struct {
        logic        is_cfg;
        logic [2:0]  index;
        logic [31:0] value;
        logic        check;
        flux_res_t   res;
    } stim_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    agp_pos_if pos_ch();
    agp_cfg_if cfg_ch();
    agp_res_if res_ch();

    asymmetric_gaussian_profile_top u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pos  (pos_ch.sink),
        .i_cfg  (cfg_ch.sink),
        .o_res  (res_ch.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [31:0] p_center;
    logic [31:0] p_sig_l;
    logic [31:0] p_sig_r;
    logic [15:0] p_sb;
    logic [15:0] p_zp;
    longint      pow2_rom[NT+1];

    flux_res_t   pending_flux[$];
    flux_res_t   pinned_flux[$];
    logic        pinned_valid[$];
    int          errors = 0;
    int          n_results = 0;
    int          n_sat = 0;
    int          n_bad = 0;
    logic        hold_off = 1'b0;

    function automatic longint floor_shr(longint v, int s);
        if (v >= 0) return v >>> s;
        return -((-v + ((64'sd1 <<< s) - 1)) >>> s);
    endfunction

    task automatic build_pow2_rom();
        longint unsigned x, term, sum;
        for (int i = 0; i < NT; i++) begin
            x = longint'(i) * agp_pkg::LN2_Q30 / NT;
            term = 64'd1 << 30;
            sum = term;
            for (int k = 1; k <= 16; k++) begin
                term = ((term * x) >> 30) / k;
                sum += term;
            end
            pow2_rom[i] = longint'(sum);
        end
        pow2_rom[NT] = 64'sd1 <<< 31;
    endtask

    task automatic set_reg(logic [2:0] idx, logic [31:0] v);
        case (idx)
            agp_pkg::CFG_CENTER:      p_center = v;
            agp_pkg::CFG_SIGMA_LEFT:  p_sig_l = v;
            agp_pkg::CFG_SIGMA_RIGHT: p_sig_r = v;
            agp_pkg::CFG_SURF_BRIGHT: p_sb = v[15:0];
            agp_pkg::CFG_ZERO_POINT:  p_zp = v[15:0];
            default: ;
        endcase
    endtask

    function automatic flux_res_t predict_flux(logic [31:0] pos);
        flux_res_t o;
        longint d, m, em, e, ip, fr, diff, mant, s;
        longint unsigned ad, sg, r, r2, g, u, k, q, fx;
        o = '0;
        d = longint'($signed(pos)) - longint'($signed(p_center));
        sg = (d < 0) ? p_sig_l : p_sig_r;
        if (sg == 0) begin
            o.bad_width = 1'b1;
            return o;
        end
        ad = (d < 0) ? -d : d;
        r = (ad << FB) / sg;
        if (r > (64'd64 << FB)) r = 64'd64 << FB;
        r2 = (r * r) >> FB;
        g = (r2 * 64'd12102203) >> 24;
        m = longint'($signed(p_zp)) - longint'($signed(p_sb));
        em = floor_shr(m * 64'sd22293082, 32 - FB);
        e = em - longint'(g);
        ip = floor_shr(e, FB);
        fr = e - ip * (64'sd1 <<< FB);
        u = longint'(fr) * NT;
        k = u >> FB;
        if (k >= NT) k = NT - 1;
        q = u - (k << FB);
        diff = pow2_rom[k+1] - pow2_rom[k];
        mant = pow2_rom[k] + floor_shr(diff * longint'(q), FB);
        if (mant < 0) mant = 0;
        s = ip - 14;
        if (s >= 32) fx = (mant != 0) ? 64'h1_0000_0000 : 0;
        else if (s >= 0) fx = longint'(mant) << s;
        else if (s > -40) fx = longint'(mant) >> (-s);
        else fx = 0;
        if (fx > 64'hFFFF_FFFF) begin
            o.flux = 32'hFFFF_FFFF;
            o.saturated = 1'b1;
        end else begin
            o.flux = fx[31:0];
        end
        return o;
    endfunction

    task automatic send_position(logic [31:0] pos);
        int gap;
        gap = $urandom_range(0, 11);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            pos_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pos_ch.valid <= 1'b1;
        pos_ch.position <= pos;
        @(posedge i_clk);
        while (!pos_ch.ready) @(posedge i_clk);
        pending_flux.insert(pending_flux.size(), predict_flux(pos));
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] v);
        pos_ch.valid <= 1'b0;
        while (pending_flux.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= v;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        set_reg(idx, v);
    endtask

    task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s expected %0h actual %0h", name, exp_v, act_v);
            errors++;
        end
    endtask

    // Receiver: random stalls, with the hold-off stretch forced by the stimulus process.
    initial begin
        flux_res_t want, got, pin;
        int stall;
        res_ch.ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            stall = $urandom_range(0, 11);
            if ($urandom_range(0, 3) == 0) stall = 0;
            if (stall != 0 || hold_off) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
                while (hold_off) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!res_ch.valid) @(posedge i_clk);
            got = '{res_ch.flux, res_ch.saturated, res_ch.bad_width};
            if (pending_flux.size() == 0) begin
                $error("unexpected result flux %0h", got.flux);
                errors++;
            end else begin
                want = pending_flux.pop_front();
                if (pinned_valid.size() != 0) begin
                    pin = pinned_flux.pop_front();
                    if (pinned_valid.pop_front()) want = pin;
                end
                check_field("flux", want.flux, got.flux);
                check_field("saturated", want.saturated, got.saturated);
                check_field("bad_width", want.bad_width, got.bad_width);
                n_results++;
                n_sat += got.saturated;
                n_bad += got.bad_width;
            end
        end
    end

    stim_row_t rows[$];

    task automatic add_cfg(logic [2:0] idx, logic [31:0] v);
        stim_row_t row;
        row = '{1'b1, idx, v, 1'b0, '0};
        rows.insert(rows.size(), row);
    endtask

    task automatic add_pos(logic [31:0] p, logic chk, flux_res_t r);
        stim_row_t row;
        row = '{1'b0, 3'd0, p, chk, r};
        rows.insert(rows.size(), row);
    endtask

    initial begin
        int tick;
        logic [31:0] pos;
        pos_ch.valid = 1'b0;
        pos_ch.position = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        p_center = 0;
        p_sig_l = agp_pkg::SIGMA_RESET;
        p_sig_r = agp_pkg::SIGMA_RESET;
        p_sb = 0;
        p_zp = 0;
        build_pow2_rom();

        // After reset, position at center gives exactly 1.0.
        add_pos(32'h0000_0000, 1'b1, '{32'h0001_0000, 1'b0, 1'b0});
        add_pos(32'h8000_0000, 1'b1, '{32'h0, 1'b0, 1'b0});
        add_pos(32'h7FFF_FFFF, 1'b1, '{32'h0, 1'b0, 1'b0});
        add_pos(32'h0001_0000, 1'b0, '0);
        add_pos(32'hFFFF_0000, 1'b0, '0);
        add_cfg(agp_pkg::CFG_SIGMA_LEFT, 32'h0);
        add_pos(32'hFFFF_FFFF, 1'b1, '{32'h0, 1'b0, 1'b1});
        add_pos(32'h0000_0000, 1'b1, '{32'h0001_0000, 1'b0, 1'b0});
        add_cfg(agp_pkg::CFG_SIGMA_RIGHT, 32'h0);
        add_pos(32'h0000_0000, 1'b1, '{32'h0, 1'b0, 1'b1});
        add_cfg(agp_pkg::CFG_SIGMA_LEFT, 32'hFFFF_FFFF);
        add_cfg(agp_pkg::CFG_SIGMA_RIGHT, 32'hFFFF_FFFF);
        add_cfg(agp_pkg::CFG_ZERO_POINT, 32'h0000_7FFF);
        add_cfg(agp_pkg::CFG_SURF_BRIGHT, 32'h0000_8000);
        add_pos(32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, 1'b1, 1'b0});
        add_pos(32'h8000_0000, 1'b0, '0);
        add_cfg(agp_pkg::CFG_ZERO_POINT, 32'h0000_8000);
        add_cfg(agp_pkg::CFG_SURF_BRIGHT, 32'h0000_7FFF);
        add_pos(32'h0000_0000, 1'b1, '{32'h0, 1'b0, 1'b0});
        add_cfg(agp_pkg::CFG_CENTER, 32'h7FFF_FFFF);
        add_cfg(agp_pkg::CFG_SURF_BRIGHT, 32'h0);
        add_cfg(agp_pkg::CFG_ZERO_POINT, 32'h0000_0A00);
        add_pos(32'h7FFF_FFFF, 1'b0, '0);
        add_pos(32'h8000_0000, 1'b0, '0);
        add_cfg(3'd7, 32'h1234_5678);
        add_pos(32'h7FFF_0000, 1'b0, '0);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            if (rows[i].is_cfg) begin
                write_reg(rows[i].index, rows[i].value);
            end else begin
                pinned_flux.insert(pinned_flux.size(), rows[i].res);
                pinned_valid.insert(pinned_valid.size(), rows[i].check);
                send_position(rows[i].value);
            end
        end

        for (int ph = 0; ph < 14; ph++) begin
            if (ph == 13) begin
                write_reg(agp_pkg::CFG_CENTER, 32'h0);
                write_reg(agp_pkg::CFG_SIGMA_LEFT, 32'h0);
                write_reg(agp_pkg::CFG_SIGMA_RIGHT, agp_pkg::SIGMA_RESET);
            end else begin
                write_reg(agp_pkg::CFG_CENTER, $urandom());
                write_reg(agp_pkg::CFG_SIGMA_LEFT, $urandom_range(0, 7) == 0 ? $urandom()
                          : $urandom_range(1, 32'h0040_0000));
                write_reg(agp_pkg::CFG_SIGMA_RIGHT, $urandom_range(0, 7) == 0 ? $urandom()
                          : $urandom_range(1, 32'h0040_0000));
            end
            write_reg(agp_pkg::CFG_SURF_BRIGHT, $urandom_range(0, 3) == 0 ? $urandom()
                      : $urandom_range(0, 16'h1800));
            write_reg(agp_pkg::CFG_ZERO_POINT, $urandom_range(0, 3) == 0 ? $urandom()
                      : $urandom_range(0, 16'h1800));
            for (int n = 0; n < 125; n++) begin
                if (ph == 5 && n == 10) begin
                    hold_off = 1'b1;
                    fork
                        begin
                            for (tick = 0; tick < 300; tick++) @(posedge i_clk);
                            hold_off = 1'b0;
                        end
                    join_none
                end
                case ($urandom_range(0, 3))
                    0: pos = $urandom();
                    default: pos = p_center + 32'({2'b00, $urandom()} %
                                   (p_sig_r > 0 ? {p_sig_r, 2'b00} : 34'd4));
                endcase
                if ($urandom_range(0, 1)) pos = p_center - (pos - p_center);
                send_position(pos);
            end
        end

        pos_ch.valid <= 1'b0;
        while (pending_flux.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
        $display("covered %0d results, %0d saturated, %0d with zero width, 14 settings",
                 n_results, n_sat, n_bad);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

endmodule
